// ===== rtl/gregorian_date_n_days_back_defines.svh =====
// Assertion macros for the date-subtract block.
`ifndef GREGORIAN_DATE_N_DAYS_BACK_DEFINES_SVH
`define GREGORIAN_DATE_N_DAYS_BACK_DEFINES_SVH

`ifndef ASSERT_OFF

`define GDATE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gdate assertion failed");

`define GDATE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gdate assertion failed");

`else

`define GDATE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GDATE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/gdate_pkg.sv =====
// Types, constants, microcode table and calendar helpers for the date-subtract block.
package gdate_pkg;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_MUL,
        UOP_CHECK,
        UOP_STEP,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_REQ,
        COND_OK,
        COND_DONE,
        COND_OUT_FREE
    } cond_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_LOAD  = 3'd0;
    localparam upc_t UPC_MUL   = 3'd1;
    localparam upc_t UPC_CHECK = 3'd2;
    localparam upc_t UPC_STEP  = 3'd3;
    localparam upc_t UPC_EMIT  = 3'd4;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  tgt;   // next step when cond holds
        upc_t  alt;   // next step otherwise
    } uword_t;

    typedef logic [4:0] mlen_t;

    localparam mlen_t MONTH_LEN [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam mlen_t      FEB_LEAP_LEN = 5'd29;
    localparam logic [3:0] FEBRUARY     = 4'd2;
    localparam logic [3:0] JANUARY      = 4'd1;
    localparam logic [3:0] DECEMBER     = 4'd12;
    localparam mlen_t      DEC_LEN      = 5'd31;

    // floor(y / 25) = (y * 5243) >> 17, exact for 14-bit y
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;
    localparam logic [4:0]  RES25_MAX   = 5'd24;

    function automatic uword_t ucode_rom(upc_t pc);
        uword_t w;
        case (pc)
            UPC_LOAD:  w = '{UOP_LOAD,  COND_REQ,      UPC_MUL,   UPC_LOAD};
            UPC_MUL:   w = '{UOP_MUL,   COND_ALWAYS,   UPC_CHECK, UPC_CHECK};
            UPC_CHECK: w = '{UOP_CHECK, COND_OK,       UPC_STEP,  UPC_EMIT};
            UPC_STEP:  w = '{UOP_STEP,  COND_DONE,     UPC_EMIT,  UPC_STEP};
            UPC_EMIT:  w = '{UOP_EMIT,  COND_OUT_FREE, UPC_LOAD,  UPC_EMIT};
            default:   w = '{UOP_NOP,   COND_ALWAYS,   UPC_LOAD,  UPC_LOAD};
        endcase
        return w;
    endfunction

    // 4/100/400 rule from the low year bits and the year mod 25
    function automatic logic is_leap(logic [3:0] y_lo, logic [4:0] rem25);
        return (y_lo[1:0] == 2'd0) && ((rem25 != 5'd0) || (y_lo == 4'd0));
    endfunction

    function automatic mlen_t days_in(logic [3:0] m, logic leap);
        mlen_t r;
        if (m == FEBRUARY && leap) begin
            r = FEB_LEAP_LEN;
        end else if (m > DECEMBER) begin
            r = 5'd0;
        end else begin
            r = MONTH_LEN[m];
        end
        return r;
    endfunction

endpackage

// ===== rtl/gregorian_date_n_days_back.sv =====
// Gregorian date minus N days, microcoded sequencer with output register.
//
// Accepts a date and a day count, checks the date (month 1..12, day within
// the month under the 4/100/400 leap rule, year >= min_year) and returns the
// date days_back days earlier; an invalid date is returned as given with
// m_in_valid low, and a step past 1 January of year 0 saturates there with
// m_underflow high. The step counter runs a five-word control program, and
// its loop word, which an invalid date skips, walks back one month per cycle
// through subtracts and the month-length table.
// A new request is taken once the result has moved to the output register.
`include "gregorian_date_n_days_back_defines.svh"

module gregorian_date_n_days_back #(
    parameter int MAX_DAYS_BACK = 4095
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [13:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_day,
    input  logic [3:0]  s_month,
    input  logic [13:0] s_year,
    input  logic [11:0] s_days_back,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_out_day,
    output logic [3:0]  m_out_month,
    output logic [13:0] m_out_year,
    output logic        m_in_valid,
    output logic        m_underflow
);
    import gdate_pkg::*;

    localparam logic [16:0] MAX_N = 17'(MAX_DAYS_BACK);

    upc_t        pc_reg, pc_next;
    logic [13:0] min_year_reg;
    logic [4:0]  d_reg, d_next;
    logic [3:0]  m_reg, m_next;
    logic [13:0] y_reg, y_next;
    logic [11:0] n_reg, n_next;
    logic [4:0]  rem_reg, rem_next;
    logic [26:0] prod_reg, prod_next;
    logic        ok_reg, ok_next;
    logic        under_reg, under_next;
    logic        m_valid_reg, m_valid_next;
    logic [4:0]  od_reg, od_next;
    logic [3:0]  om_reg, om_next;
    logic [13:0] oy_reg, oy_next;
    logic        ook_reg, ook_next;
    logic        oun_reg, oun_next;

    uword_t      uw;
    logic        cond_c, ok_c, done_c, out_free;
    logic [9:0]  q25;
    logic [13:0] q25x;
    logic [13:0] diff;
    logic [4:0]  rem_c;
    logic [3:0]  m_dec;
    logic [4:0]  rem_dec;
    logic        out_floor;
    logic        out_month_ok;

    assign uw       = ucode_rom(pc_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (pc_reg == UPC_LOAD);

    assign q25   = prod_reg[DIV25_SHIFT +: 10];
    assign q25x  = 14'({q25, 4'b0}) + 14'({q25, 3'b0}) + 14'(q25);
    assign diff  = y_reg - q25x;
    assign rem_c = diff[4:0];
    assign ok_c  = (m_reg >= JANUARY) && (m_reg <= DECEMBER) && (d_reg != 5'd0)
                && (d_reg <= days_in(m_reg, is_leap(y_reg[3:0], rem_c)))
                && (y_reg >= min_year_reg);

    assign done_c  = (n_reg == 12'd0) || (n_reg < 12'(d_reg))
                  || (m_reg == JANUARY && y_reg == 14'd0);
    assign m_dec   = m_reg - 4'd1;
    assign rem_dec = (rem_reg == 5'd0) ? RES25_MAX : rem_reg - 5'd1;

    always_comb begin
        case (uw.cond)
            COND_ALWAYS:   cond_c = 1'b1;
            COND_REQ:      cond_c = s_valid;
            COND_OK:       cond_c = ok_c;
            COND_DONE:     cond_c = done_c;
            COND_OUT_FREE: cond_c = out_free;
            default:       cond_c = 1'b1;
        endcase
        pc_next = cond_c ? uw.tgt : uw.alt;
    end

    always_comb begin
        d_next       = d_reg;
        m_next       = m_reg;
        y_next       = y_reg;
        n_next       = n_reg;
        rem_next     = rem_reg;
        prod_next    = prod_reg;
        ok_next      = ok_reg;
        under_next   = under_reg;
        m_valid_next = m_valid_reg && !m_ready;
        od_next      = od_reg;
        om_next      = om_reg;
        oy_next      = oy_reg;
        ook_next     = ook_reg;
        oun_next     = oun_reg;
        case (uw.op)
            UOP_LOAD: begin
                if (s_valid) begin
                    d_next     = s_day;
                    m_next     = s_month;
                    y_next     = s_year;
                    n_next     = (17'(s_days_back) > MAX_N) ? MAX_N[11:0] : s_days_back;
                    ok_next    = 1'b0;
                    under_next = 1'b0;
                end
            end
            UOP_MUL: begin
                prod_next = 27'(y_reg) * 27'(DIV25_MUL);
            end
            UOP_CHECK: begin
                rem_next = rem_c;
                ok_next  = ok_c;
            end
            UOP_STEP: begin
                if (n_reg == 12'd0) begin
                    n_next = n_reg;
                end else if (n_reg < 12'(d_reg)) begin
                    d_next = d_reg - n_reg[4:0];
                    n_next = 12'd0;
                end else begin
                    n_next = n_reg - 12'(d_reg);
                    if (m_reg == JANUARY) begin
                        if (y_reg == 14'd0) begin
                            d_next     = 5'd1;
                            m_next     = JANUARY;
                            n_next     = 12'd0;
                            under_next = 1'b1;
                        end else begin
                            y_next   = y_reg - 14'd1;
                            rem_next = rem_dec;
                            m_next   = DECEMBER;
                            d_next   = DEC_LEN;
                        end
                    end else begin
                        m_next = m_dec;
                        d_next = days_in(m_dec, is_leap(y_reg[3:0], rem_reg));
                    end
                end
            end
            UOP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    od_next      = d_reg;
                    om_next      = m_reg;
                    oy_next      = y_reg;
                    ook_next     = ok_reg;
                    oun_next     = under_reg;
                end
            end
            default: begin
                ok_next = ok_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= UPC_LOAD;
            m_valid_reg  <= 1'b0;
            min_year_reg <= 14'd2020;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                min_year_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        d_reg     <= d_next;
        m_reg     <= m_next;
        y_reg     <= y_next;
        n_reg     <= n_next;
        rem_reg   <= rem_next;
        prod_reg  <= prod_next;
        ok_reg    <= ok_next;
        under_reg <= under_next;
        od_reg    <= od_next;
        om_reg    <= om_next;
        oy_reg    <= oy_next;
        ook_reg   <= ook_next;
        oun_reg   <= oun_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_day   = od_reg;
    assign m_out_month = om_reg;
    assign m_out_year  = oy_reg;
    assign m_in_valid  = ook_reg;
    assign m_underflow = oun_reg;

    assign out_floor    = (m_out_day == 5'd1) && (m_out_month == JANUARY)
                       && (m_out_year == 14'd0);
    assign out_month_ok = (m_out_month >= JANUARY) && (m_out_month <= DECEMBER)
                       && (m_out_day != 5'd0);

    `GDATE_ASSERT_NXT(a_req_starts_program, aclk, aresetn, s_valid && s_ready, pc_reg == UPC_MUL)
    `GDATE_ASSERT_IMP(a_rem_in_range, aclk, aresetn, pc_reg == UPC_STEP, rem_reg <= RES25_MAX)
    `GDATE_ASSERT_IMP(a_under_needs_ok, aclk, aresetn, m_valid && m_underflow, m_in_valid)
    `GDATE_ASSERT_IMP(a_under_saturates, aclk, aresetn, m_valid && m_underflow, out_floor)
    `GDATE_ASSERT_IMP(a_valid_month, aclk, aresetn, m_valid && m_in_valid, out_month_ok)

endmodule
